FILE: hw/rtl/dtsf_pkg.sv
// Shared types and constants for the dual tap sawtooth flanger.
// Used by dtsf_ctrl, dtsf_dpath and dual_tap_sawtooth_flanger; no dependencies.
package dtsf_pkg;

   localparam int STORE_DEPTH_DEFAULT = 4096;

   localparam int SAMPLE_W   = 16;
   localparam int DEPTH_W    = 19;
   localparam int DELAY_W    = 19;
   localparam int PHASE_W    = 32;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_LFO_DEPTH  = 3'd0;
   localparam csr_index_type REG_PREDELAY   = 3'd1;
   localparam csr_index_type REG_PHASE_STEP = 3'd2;
   localparam csr_index_type REG_GAIN_A     = 3'd3;
   localparam csr_index_type REG_GAIN_B     = 3'd4;

   localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd16384;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADDR,
      ST_RD_LO,
      ST_RD_HI,
      ST_INTERP,
      ST_GAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;       // latch input sample, clear accumulator
      logic sel;        // 0: tap a, 1: tap b
      logic mul_en;     // depth * sawtooth
      logic addr_en;    // delay clamp and read position
      logic rd_hi;      // memory address on the upper neighbor, capture lower one
      logic interp_en;  // linear interpolation
      logic gain_en;    // gain multiply and accumulate
      logic commit;     // write sample, advance index and phase, load result
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } status_type;

endpackage

FILE: hw/rtl/dual_tap_sawtooth_flanger.sv
// Top level of the dual tap sawtooth flanger: sequencer plus datapath.
// Depends on dtsf_pkg, dtsf_ctrl and dtsf_dpath.
//
// Mono flanger, one instance per channel. Each sample accepted on the req_ channel
// yields exactly one saturated Q1.15 sample on the rsp_ channel. The block works on one
// sample at a time and steps through an accept state, then for each of the two taps
// phase multiply, address, two interpolation reads, interpolate and gain accumulate,
// and last a commit state; the four reads and the write of the new sample share the
// single port of the delay memory. The result sits in an output register, so the next
// sample is taken while that result waits; a stall lasting past the next commit holds
// the block. No clearing pass follows reset: a fill mark makes unwritten entries read
// as zero. Write the csr_ registers only while the block is idle.
module dual_tap_sawtooth_flanger #(
   parameter int STORE_DEPTH = dtsf_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [dtsf_pkg::SAMPLE_W-1:0]  req_in_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dtsf_pkg::SAMPLE_W-1:0]  rsp_out_sample,
   input  logic                                  csr_we,
   input  dtsf_pkg::csr_index_type               csr_index,
   input  logic [dtsf_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import dtsf_pkg::*;

   cmd_type    cmd;
   status_type sts;

   dtsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dtsf_dpath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_in_sample  (req_in_sample),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_sample (rsp_out_sample),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule

FILE: hw/rtl/dtsf_ctrl.sv
// Sequencer for the flanger: steps one sample through both taps and the commit.
// Depends on dtsf_pkg for the state enum and the command/status structs.
module dtsf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dtsf_pkg::status_type   sts,
   output dtsf_pkg::cmd_type      cmd
);
   import dtsf_pkg::*;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cmd       = '0;
      cmd.sel   = sel_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               sel_in   = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.addr_en = 1'b1;
            state_in    = ST_RD_LO;
         end
         ST_RD_LO: begin
            state_in = ST_RD_HI;
         end
         ST_RD_HI: begin
            cmd.rd_hi = 1'b1;
            state_in  = ST_INTERP;
         end
         ST_INTERP: begin
            cmd.interp_en = 1'b1;
            state_in      = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain_en = 1'b1;
            if (sel_ff) begin
               state_in = ST_COMMIT;
            end else begin
               sel_in   = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_COMMIT: begin
            // hold until the output register can take the beat
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               sel_in     = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MUL && !sel_ff))
      else $error("accepted beat did not start on tap a");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && !sts.rsp_free) |=> (state_ff == ST_COMMIT))
      else $error("commit left while output register was busy");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAIN && !sel_ff) |=> (state_ff == ST_MUL && sel_ff))
      else $error("tap b not started after tap a");

endmodule

FILE: hw/rtl/dtsf_dpath.sv
// Flanger datapath: control registers, LFO phase, delay memory, tap math and output register.
// Depends on dtsf_pkg; driven by commands from dtsf_ctrl.
module dtsf_dpath #(
   parameter int STORE_DEPTH = dtsf_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  dtsf_pkg::csr_index_type               csr_index,
   input  logic [dtsf_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [dtsf_pkg::SAMPLE_W-1:0]  req_in_sample,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic signed [dtsf_pkg::SAMPLE_W-1:0]  rsp_out_sample,
   input  dtsf_pkg::cmd_type                     cmd,
   output dtsf_pkg::status_type                  sts
);
   import dtsf_pkg::*;

   localparam int AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int PW   = AW + 8;                       // read position, 8 fraction bits
   localparam int SW   = (PW + 2 > DEPTH_W + 3) ? PW + 2 : DEPTH_W + 3;
   localparam int TMW  = DEPTH_W + 2;                  // depth term
   localparam int PRW  = DEPTH_W + 1 + PHASE_W;        // depth * saw product
   localparam int TW   = SAMPLE_W + 10;                // interpolated tap
   localparam int GPW  = GAIN_W + TW;
   localparam int ACW  = GPW + 1;
   localparam int YW   = ACW - 23;

   localparam logic signed [SW-1:0]  MAX_DELAY  = SW'((STORE_DEPTH - 1) * 256);
   localparam logic signed [SW-1:0]  WRAP_SPAN  = SW'(STORE_DEPTH * 256);
   localparam logic [AW-1:0]         LAST_IDX   = AW'(STORE_DEPTH - 1);
   localparam logic signed [ACW-1:0] ROUND_HALF = ACW'(64'sd4194304);
   localparam logic signed [YW-1:0]  Y_MAX      = YW'(32767);
   localparam logic signed [YW-1:0]  Y_MIN      = YW'(-32768);

   // control registers
   logic [DEPTH_W-1:0]        lfo_depth_ff;
   logic [DELAY_W-1:0]        predelay_ff;
   logic [PHASE_W-1:0]        phase_step_ff;
   logic signed [GAIN_W-1:0]  gain_a_ff, gain_b_ff;

   // running state
   logic [PHASE_W-1:0]        phase_ff;
   logic [AW-1:0]             wr_idx_ff;
   logic                      wrap_ff;   // every entry has been written once

   // work registers
   logic [SAMPLE_W-1:0]       x_ff;
   logic signed [PRW-1:0]     prod_ff;
   logic [AW-1:0]             idx_ff, nxt_ff;
   logic [7:0]                frac_ff;
   logic [SAMPLE_W-1:0]       rd_data_ff;
   logic                      rd_ok_ff;
   logic signed [SAMPLE_W-1:0] s0_ff;
   logic signed [TW-1:0]      tap_ff;
   logic signed [ACW-1:0]     acc_ff;
   logic                      rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_out_sample_ff;

   logic [SAMPLE_W-1:0]       mem [STORE_DEPTH];
   logic [AW-1:0]             mem_addr;

   // combinational
   logic signed [PHASE_W-1:0] saw;
   logic signed [TMW-1:0]     term;
   logic signed [SW-1:0]      delay_raw, delay_cl, pos_raw, pos;
   logic [AW-1:0]             idx, nxt;
   logic signed [SAMPLE_W-1:0] s1;
   logic signed [SAMPLE_W:0]  diff;
   logic signed [TW-1:0]      fprod, tap;
   logic signed [GAIN_W-1:0]  gain;
   logic signed [GPW-1:0]     gprod;
   logic signed [ACW-1:0]     rnd;
   logic signed [YW-1:0]      y;
   logic signed [SAMPLE_W-1:0] y_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         lfo_depth_ff  <= '0;
         predelay_ff   <= '0;
         phase_step_ff <= '0;
         gain_a_ff     <= GAIN_RESET;
         gain_b_ff     <= GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LFO_DEPTH:  lfo_depth_ff  <= csr_wdata[DEPTH_W-1:0];
            REG_PREDELAY:   predelay_ff   <= csr_wdata[DELAY_W-1:0];
            REG_PHASE_STEP: phase_step_ff <= csr_wdata[PHASE_W-1:0];
            REG_GAIN_A:     gain_a_ff     <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_B:     gain_b_ff     <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // tap b sits half an LFO period later: flip the phase MSB
   assign saw  = {phase_ff[PHASE_W-1] ^ cmd.sel, phase_ff[PHASE_W-2:0]};
   assign term = prod_ff[PRW-1:31];

   always_comb begin
      delay_raw = $signed({{(SW-DELAY_W){1'b0}}, predelay_ff})
                + $signed({{(SW-TMW){term[TMW-1]}}, term});
      if (delay_raw[SW-1]) begin
         delay_cl = '0;
      end else if (delay_raw > MAX_DELAY) begin
         delay_cl = MAX_DELAY;
      end else begin
         delay_cl = delay_raw;
      end
      pos_raw = $signed({{(SW-PW){1'b0}}, wr_idx_ff, 8'h00}) - delay_cl;
      pos     = pos_raw[SW-1] ? pos_raw + WRAP_SPAN : pos_raw;
      idx     = pos[PW-1:8];
      nxt     = (idx == LAST_IDX) ? '0 : idx + AW'(1);
   end

   // entries never written read as zero
   assign s1    = rd_ok_ff ? rd_data_ff : '0;
   assign diff  = $signed({s1[SAMPLE_W-1], s1}) - $signed({s0_ff[SAMPLE_W-1], s0_ff});
   assign fprod = TW'($signed({1'b0, frac_ff})) * TW'(diff);
   assign tap   = $signed({{2{s0_ff[SAMPLE_W-1]}}, s0_ff, 8'h00}) + fprod;

   assign gain  = cmd.sel ? gain_b_ff : gain_a_ff;
   assign gprod = GPW'(gain) * GPW'(tap_ff);

   always_comb begin
      rnd = acc_ff + ROUND_HALF;
      y   = rnd[ACW-1:23];
      if (y > Y_MAX) begin
         y_sat = Y_MAX[SAMPLE_W-1:0];
      end else if (y < Y_MIN) begin
         y_sat = Y_MIN[SAMPLE_W-1:0];
      end else begin
         y_sat = y[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_in_sample;
      end
      if (cmd.mul_en) begin
         prod_ff <= PRW'($signed({1'b0, lfo_depth_ff})) * PRW'(saw);
      end
      if (cmd.addr_en) begin
         idx_ff  <= idx;
         nxt_ff  <= nxt;
         frac_ff <= pos[7:0];
      end
      if (cmd.rd_hi) begin
         s0_ff <= rd_ok_ff ? rd_data_ff : '0;
      end
      if (cmd.interp_en) begin
         tap_ff <= tap;
      end
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (cmd.gain_en) begin
         acc_ff <= acc_ff + ACW'(gprod);
      end
      if (cmd.commit) begin
         rsp_out_sample_ff <= y_sat;
      end
   end

   // single port: one read or the sample write per cycle
   always_comb begin
      if (cmd.commit) begin
         mem_addr = wr_idx_ff;
      end else if (cmd.rd_hi) begin
         mem_addr = nxt_ff;
      end else begin
         mem_addr = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         mem[mem_addr] <= x_ff;
      end
      rd_data_ff <= mem[mem_addr];
      rd_ok_ff   <= wrap_ff || (mem_addr < wr_idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         wr_idx_ff    <= '0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            phase_ff     <= phase_ff + phase_step_ff;
            rsp_valid_ff <= 1'b1;
            if (wr_idx_ff == LAST_IDX) begin
               wr_idx_ff <= '0;
               wrap_ff   <= 1'b1;
            end else begin
               wr_idx_ff <= wr_idx_ff + AW'(1);
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_out_sample_ff;
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("commit would overwrite a stalled beat");

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> ($stable(wr_idx_ff) && $stable(phase_ff)))
      else $error("index or phase moved without a commit");

endmodule
